// File: rtl/gf128_hash_accumulator_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef GF128_HASH_ACCUMULATOR_CORE_ASSERT_SVH
`define GF128_HASH_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GHAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghac assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define GHAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghac assertion failed");

`endif

// File: rtl/ghac_pkg.sv
package ghac_pkg;

  localparam int unsigned HALF_W  = 64;
  localparam int unsigned BLK_W   = 2 * HALF_W;
  localparam int unsigned CNT_B_W = 5;
  localparam int unsigned BYTES   = BLK_W / 8;
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned DIGITS  = BLK_W / DIGIT_W;
  localparam int unsigned STEP_W  = $clog2(DIGITS);
  localparam int unsigned IDX_W   = 1;

  // GCM reduction constant: 0xe1 followed by 120 zero bits
  localparam logic [BLK_W-1:0] REDUCE_POLY = {8'he1, {(BLK_W-8){1'b0}}};

  localparam logic [IDX_W-1:0] REG_HASH_KEY_HI = 1'b0;
  localparam logic [IDX_W-1:0] REG_HASH_KEY_LO = 1'b1;

  typedef struct packed {
    logic load;      // capture a new block and start the multiply
    logic step;      // absorb one digit of the multiplicand
    logic commit;    // final digit: write the product to the accumulator
    logic load_out;  // copy the accumulator into the output register
  } cmd_t;

  typedef struct packed {
    logic last;      // block under work is marked last
  } sts_t;

endpackage

// File: rtl/ghac_if.sv
interface ghac_in_if;
  logic                         valid;
  logic                         ready;
  logic                         start_new;
  logic [ghac_pkg::HALF_W-1:0]  block_hi;
  logic [ghac_pkg::HALF_W-1:0]  block_lo;
  logic [ghac_pkg::CNT_B_W-1:0] valid_bytes;
  logic                         last_block;

  modport source (output valid, start_new, block_hi, block_lo, valid_bytes, last_block,
                  input ready);
  modport sink   (input valid, start_new, block_hi, block_lo, valid_bytes, last_block,
                  output ready);
endinterface

interface ghac_out_if;
  logic                        valid;
  logic                        ready;
  logic [ghac_pkg::HALF_W-1:0] digest_hi;
  logic [ghac_pkg::HALF_W-1:0] digest_lo;

  modport source (output valid, digest_hi, digest_lo, input ready);
  modport sink   (input valid, digest_hi, digest_lo, output ready);
endinterface

interface ghac_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ghac_pkg::IDX_W-1:0] index;
  logic [ghac_pkg::HALF_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ghac_dp.sv
module ghac_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ghac_pkg::cmd_t               cmd,
  output ghac_pkg::sts_t               sts,
  input  logic                         cfg_we,
  input  logic [ghac_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ghac_pkg::HALF_W-1:0]  cfg_data,
  input  logic                         start_new,
  input  logic [ghac_pkg::HALF_W-1:0]  block_hi,
  input  logic [ghac_pkg::HALF_W-1:0]  block_lo,
  input  logic [ghac_pkg::CNT_B_W-1:0] valid_bytes,
  input  logic                         last_block,
  output logic [ghac_pkg::HALF_W-1:0]  digest_hi,
  output logic [ghac_pkg::HALF_W-1:0]  digest_lo
);

  localparam int unsigned BLK_W  = ghac_pkg::BLK_W;
  localparam int unsigned HALF_W = ghac_pkg::HALF_W;

  logic [HALF_W-1:0] key_hi_r, key_lo_r;
  logic [BLK_W-1:0]  acc_r;
  logic [BLK_W-1:0]  x_r, v_r, z_r;
  logic [BLK_W-1:0]  v_nxt, z_nxt, x_nxt;
  logic [BLK_W-1:0]  mask;
  logic [ghac_pkg::CNT_B_W-1:0] n_sat;
  logic              last_r;
  logic [HALF_W-1:0] dig_hi_r, dig_lo_r;

  // saturate the byte count, then keep the leading bytes
  always_comb begin
    n_sat = (valid_bytes > ghac_pkg::CNT_B_W'(ghac_pkg::BYTES)) ?
            ghac_pkg::CNT_B_W'(ghac_pkg::BYTES) : valid_bytes;
    for (int k = 0; k < ghac_pkg::BYTES; k++) begin
      mask[BLK_W-1-8*k -: 8] = (ghac_pkg::CNT_B_W'(k) < n_sat) ? 8'hff : 8'h00;
    end
  end

  assign x_nxt = ({block_hi, block_lo} & mask) ^ (start_new ? '0 : acc_r);

  // one digit of the multiplicand, most significant bit first
  always_comb begin
    z_nxt = z_r;
    v_nxt = v_r;
    for (int j = 0; j < ghac_pkg::DIGIT_W; j++) begin
      if (x_r[BLK_W-1-j]) begin
        z_nxt = z_nxt ^ v_nxt;
      end
      if (v_nxt[0]) begin
        v_nxt = (v_nxt >> 1) ^ ghac_pkg::REDUCE_POLY;
      end else begin
        v_nxt = v_nxt >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      acc_r    <= '0;
      last_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ghac_pkg::REG_HASH_KEY_HI: key_hi_r <= cfg_data;
          ghac_pkg::REG_HASH_KEY_LO: key_lo_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        last_r <= last_block;
      end
      if (cmd.step && cmd.commit) begin
        acc_r <= z_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= x_nxt;
      v_r <= {key_hi_r, key_lo_r};
      z_r <= '0;
    end else if (cmd.step) begin
      x_r <= x_r << ghac_pkg::DIGIT_W;
      v_r <= v_nxt;
      z_r <= z_nxt;
    end
    if (cmd.load_out) begin
      dig_hi_r <= acc_r[BLK_W-1:HALF_W];
      dig_lo_r <= acc_r[HALF_W-1:0];
    end
  end

  assign sts.last  = last_r;
  assign digest_hi = dig_hi_r;
  assign digest_lo = dig_lo_r;

endmodule

// File: rtl/ghac_ctrl.sv
module ghac_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ghac_pkg::sts_t sts,
  output ghac_pkg::cmd_t cmd
);

  localparam int unsigned STEP_W = ghac_pkg::STEP_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ghac_pkg::DIGITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DELIVER
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] cnt_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;

  assign out_free     = !out_valid_r || out_ready;
  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.load     = in_valid && in_ready;
  assign cmd.step     = (state_r == S_RUN);
  assign cmd.commit   = (state_r == S_RUN) && (cnt_r == LAST_STEP);
  assign cmd.load_out = (state_r == S_DELIVER) && out_free;

  // drop the beat once taken, raise it when a new digest moves in
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            state_r <= sts.last ? S_DELIVER : S_IDLE;
          end
        end
        S_DELIVER: begin
          // hold the digest until the output register frees up
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/gf128_hash_accumulator_core.sv
// GHASH multiply-accumulate over GF(2^128), GCM bit-reflected form, byte 0 most
// significant. Each input beat carries one 16-byte block, zero-padded after
// valid_bytes (counts above 16 act as 16); start_new clears the accumulator first.
// The sum of accumulator and block is multiplied by the hash key eight
// multiplicand bits per cycle, so a block is captured and then runs 16 multiply
// steps before the next block is accepted. A block marked last_block then passes
// a deliver state that moves the digest into the output register once the
// previous digest there has been taken. Key writes (index 0 upper, 1 lower half) are
// always taken and apply from the next accepted block.
module gf128_hash_accumulator_core (
  input  logic        clk,
  input  logic        rst_n,
  ghac_in_if.sink     in_blk,
  ghac_out_if.source  out_dig,
  ghac_cfg_if.sink    cfg_wr
);

  ghac_pkg::cmd_t cmd;
  ghac_pkg::sts_t sts;

  assign cfg_wr.ready = 1'b1;

  ghac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_blk.valid),
    .in_ready  (in_blk.ready),
    .out_valid (out_dig.valid),
    .out_ready (out_dig.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ghac_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_wr.valid),
    .cfg_index   (cfg_wr.index),
    .cfg_data    (cfg_wr.data),
    .start_new   (in_blk.start_new),
    .block_hi    (in_blk.block_hi),
    .block_lo    (in_blk.block_lo),
    .valid_bytes (in_blk.valid_bytes),
    .last_block  (in_blk.last_block),
    .digest_hi   (out_dig.digest_hi),
    .digest_lo   (out_dig.digest_lo)
  );

endmodule

// File: rtl/ghac_checker.sv
`include "gf128_hash_accumulator_core_assert.svh"

module ghac_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ghac_pkg::HALF_W-1:0] digest_hi,
  input logic [ghac_pkg::HALF_W-1:0] digest_lo,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  logic in_beat, out_stall;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // one block at a time: busy right after a beat and through all multiply steps
  `GHAC_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready)
  `GHAC_ASSERT_NEXT(a_busy_full_multiply, in_beat, ##15 !in_ready)
  `GHAC_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)
  `GHAC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(digest_hi) && $stable(digest_lo))

endmodule

bind gf128_hash_accumulator_core ghac_checker u_ghac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_blk.valid),
  .in_ready  (in_blk.ready),
  .out_valid (out_dig.valid),
  .out_ready (out_dig.ready),
  .digest_hi (out_dig.digest_hi),
  .digest_lo (out_dig.digest_lo),
  .cfg_valid (cfg_wr.valid),
  .cfg_ready (cfg_wr.ready)
);

// File: bench/gf128_hash_accumulator_core_test.sv
`timescale 1ns / 100ps

module gf128_hash_accumulator_core_test;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int REPORT_LIMIT   = 10;

  logic clk;
  logic rst_n;

  ghac_in_if  in_blk();
  ghac_out_if out_dig();
  ghac_cfg_if cfg_wr();

  gf128_hash_accumulator_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_blk  (in_blk),
    .out_dig (out_dig),
    .cfg_wr  (cfg_wr)
  );

  // Predictor state: current key, running hash and digests still to arrive
  logic [ghac_pkg::BLK_W-1:0] hash_key;
  logic [ghac_pkg::BLK_W-1:0] running_hash;
  logic [ghac_pkg::BLK_W-1:0] digest_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_count;
  int fail_count;
  int cycle_count;

  function automatic logic [ghac_pkg::BLK_W-1:0] ghash_mul(
    logic [ghac_pkg::BLK_W-1:0] x, logic [ghac_pkg::BLK_W-1:0] h);
    logic [ghac_pkg::BLK_W-1:0] z;
    logic [ghac_pkg::BLK_W-1:0] v;
    int i;
    z = '0;
    v = h;
    for (i = 0; i < ghac_pkg::BLK_W; i++) begin
      if (x[ghac_pkg::BLK_W-1-i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ ghac_pkg::REDUCE_POLY) : (v >> 1);
    end
    return z;
  endfunction

  function automatic logic [ghac_pkg::BLK_W-1:0] byte_mask(
    logic [ghac_pkg::CNT_B_W-1:0] count);
    int n;
    n = (count > ghac_pkg::BYTES) ? int'(ghac_pkg::BYTES) : int'(count);
    if (n == 0) return '0;
    return {ghac_pkg::BLK_W{1'b1}} << (8 * (int'(ghac_pkg::BYTES) - n));
  endfunction

  function automatic logic [ghac_pkg::HALF_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Fold one accepted block into the running hash
  function automatic void absorb_block(bit start, logic [ghac_pkg::HALF_W-1:0] hi,
                                       logic [ghac_pkg::HALF_W-1:0] lo,
                                       logic [ghac_pkg::CNT_B_W-1:0] count, bit last);
    if (start) running_hash = '0;
    running_hash = ghash_mul(running_hash ^ ({hi, lo} & byte_mask(count)), hash_key);
    if (last) digest_q.push_back(running_hash);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls plus an occasional long hold-off
  initial begin : digest_sink
    int stall_left;
    int hold_off_seen;
    stall_left = 0;
    hold_off_seen = 0;
    out_dig.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_seen != hold_off_count) begin
        hold_off_seen = hold_off_count;
        stall_left = HOLD_OFF_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_dig.ready <= 1'b0;
      end else begin
        out_dig.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic [ghac_pkg::BLK_W-1:0] want;
    if (rst_n && out_dig.valid && out_dig.ready) begin
      if (digest_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("digest with none expected: %h_%h", out_dig.digest_hi, out_dig.digest_lo);
      end else begin
        want = digest_q.pop_front();
        if (want[ghac_pkg::BLK_W-1:ghac_pkg::HALF_W] !== out_dig.digest_hi ||
            want[ghac_pkg::HALF_W-1:0] !== out_dig.digest_lo) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("digest mismatch: expected %h_%h got %h_%h",
                     want[ghac_pkg::BLK_W-1:ghac_pkg::HALF_W], want[ghac_pkg::HALF_W-1:0],
                     out_dig.digest_hi, out_dig.digest_lo);
        end
      end
    end
  end

  task automatic send_block(bit start, logic [ghac_pkg::HALF_W-1:0] hi,
                            logic [ghac_pkg::HALF_W-1:0] lo,
                            logic [ghac_pkg::CNT_B_W-1:0] count, bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_blk.valid <= 1'b0;
      @(negedge clk);
    end
    in_blk.valid       <= 1'b1;
    in_blk.start_new   <= start;
    in_blk.block_hi    <= hi;
    in_blk.block_lo    <= lo;
    in_blk.valid_bytes <= count;
    in_blk.last_block  <= last;
    do @(posedge clk); while (!in_blk.ready);
    absorb_block(start, hi, lo, count, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_blk.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    // a block without last_block may still be in the multiplier
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(logic [ghac_pkg::HALF_W-1:0] hi, logic [ghac_pkg::HALF_W-1:0] lo);
    wait_idle();
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= ghac_pkg::REG_HASH_KEY_HI;
    cfg_wr.data  <= hi;
    do @(posedge clk); while (!cfg_wr.ready);
    hash_key[ghac_pkg::BLK_W-1:ghac_pkg::HALF_W] = hi;
    @(negedge clk);
    cfg_wr.index <= ghac_pkg::REG_HASH_KEY_LO;
    cfg_wr.data  <= lo;
    do @(posedge clk); while (!cfg_wr.ready);
    hash_key[ghac_pkg::HALF_W-1:0] = lo;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  // Key is zero out of reset, so every digest is zero
  task automatic test_reset_key();
    send_block(1'b1, '1, '1, 5'd16, 1'b1);
    send_block(1'b0, rand64(), rand64(), 5'd16, 1'b1);
  endtask

  // GCM multiplicative identity makes the byte masking directly visible
  task automatic test_byte_counts();
    logic [ghac_pkg::CNT_B_W-1:0] counts[9];
    int i;
    counts = '{5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd31};
    write_key(64'h8000_0000_0000_0000, 64'h0);
    for (i = 0; i < 9; i++) send_block(1'b1, '1, '1, counts[i], 1'b1);
  endtask

  task automatic test_key_extremes();
    write_key('1, '1);
    send_block(1'b1, '1, '1, 5'd16, 1'b0);
    send_block(1'b0, '0, '0, 5'd0, 1'b1);
    // carry on from the previous digest without a restart
    send_block(1'b0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd16, 1'b1);
    write_key(64'h0, 64'h1);
    send_block(1'b1, 64'h8000_0000_0000_0000, 64'h1, 5'd16, 1'b0);
    // key change in the middle of a message applies to the next block
    write_key(64'h0, 64'h0);
    send_block(1'b0, rand64(), rand64(), 5'd16, 1'b1);
    write_key(rand64(), rand64());
    send_block(1'b1, '0, '0, 5'd16, 1'b0);
    send_block(1'b0, '1, '1, 5'd12, 1'b1);
  endtask

  // Hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    int i;
    hold_off_count++;
    for (i = 0; i < 16; i++) send_block(1'b1, rand64(), rand64(), 5'd16, 1'b1);
  endtask

  task automatic test_random_messages(int n_items);
    int sent;
    int len;
    int k;
    bit last;
    logic [ghac_pkg::CNT_B_W-1:0] count;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(11) == 0) write_key(rand64(), rand64());
      if ($urandom_range(99) < 15) begin
        send_block(bit'($urandom_range(1)), rand64(), rand64(),
                   ghac_pkg::CNT_B_W'($urandom_range(31)), bit'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          last = (k == len - 1);
          count = last ? ghac_pkg::CNT_B_W'($urandom_range(1, 16)) : 5'd16;
          if ($urandom_range(7) == 0) count = ghac_pkg::CNT_B_W'($urandom_range(31));
          send_block(k == 0, rand64(), rand64(), count, last);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_blk.valid       = 1'b0;
    in_blk.start_new   = 1'b0;
    in_blk.block_hi    = '0;
    in_blk.block_lo    = '0;
    in_blk.valid_bytes = '0;
    in_blk.last_block  = 1'b0;
    cfg_wr.valid       = 1'b0;
    cfg_wr.index       = ghac_pkg::REG_HASH_KEY_HI;
    cfg_wr.data        = '0;
    hash_key           = '0;
    running_hash       = '0;
    hold_off_count     = 0;
    fail_count         = 0;
    cycle_count        = 0;
    send_idle_pct      = 38;
    recv_idle_pct      = 53;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_byte_counts();
    test_key_extremes();
    test_random_messages(500);

    wait_idle();
    send_idle_pct = 53;
    recv_idle_pct = 38;
    test_random_messages(500);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_messages(400);

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
